@@ design/fmeg_pkg.sv @@
// Shared types, register indexes and helper functions of the FM envelope generator.
`default_nettype none

package fmeg_pkg;

   // Default values of the top-level parameters.
   localparam int LOG_RESOLUTION_DEF = 12;
   localparam int ENVELOPE_SHIFT_DEF = 7;

   // Fixed field widths of the streams.
   localparam int ATT_W       = 25;
   localparam int STAGE_W     = 3;
   localparam int AM_W        = 10;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 6;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_RATE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_RATE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSTAIN_LEVEL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_RATE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SUSTAINED_TONE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_SCALE_MODE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL_LEVEL     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_AM_ENABLE       = 3'd7;

   // Key-scale rate mode that disables scaling, and the first mode that uses full scaling.
   localparam logic [2:0] RSM_OFF  = 3'd0;
   localparam logic [2:0] RSM_FULL = 3'd4;

   // Item kinds on the request channel.
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_UPDATE = 1'b1;

   // Configuration register file.
   typedef struct packed {
      logic [3:0] attack_rate;
      logic [3:0] decay_rate;
      logic [3:0] sustain_level;
      logic [3:0] release_rate;
      logic       sustained_tone;
      logic [2:0] rate_scale_mode;
      logic [5:0] total_level;
      logic       am_enable;
   } cfg_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic            mode;
      logic            key_on;
      logic            sustain_on;
      logic [AM_W-1:0] am_offset;
      logic [3:0]      attack_shift;
      logic [5:0]      decay_step;
      logic [5:0]      release_step;
   } q_item_type;

   // Handshake between the queue and the back end.
   typedef struct packed {
      logic valid;
      logic pop;
   } q_ctl_type;

   // Rate plus key-scale offset, limited to the top rate.
   function automatic logic [5:0] cap63(input logic [6:0] v);
      logic [5:0] r;
      r = (v > 7'd63) ? 6'd63 : v[5:0];
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/fm_operator_envelope_generator_unit.sv @@
// Top level of the FM operator envelope generator: register file, front, queue and back.
// A request item passes through the queue, the middle stage and the output register to rsp.
// Throughput: one item per cycle while rsp is not stalled; the envelope update is combinational.
// A two-entry queue and the output register let either side stall without losing items.
// Reset (synchronous, active high) clears the registers, the envelope state and the queue.
`default_nettype none

module fm_operator_envelope_generator_unit
   import fmeg_pkg::*;
#(
   parameter int LOG_RESOLUTION = LOG_RESOLUTION_DEF,
   parameter int ENVELOPE_SHIFT = ENVELOPE_SHIFT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,  // key_on, sustain_on, freq_high[3:0], am_offset[9:0]
   input  wire logic                   req_tuser,  // mode
   // Result stream.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,  // attenuation[24:0], stage[2:0], zero pad
   // Configuration writes.
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type          cfg_ff;
   logic             q_full;
   logic             push;
   q_item_type       push_item;
   q_item_type       head_item;
   logic             head_valid;
   q_ctl_type        q_ctl;
   logic [ATT_W-1:0] rsp_attenuation;
   logic [STAGE_W-1:0] rsp_stage;

   // Configuration register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ATTACK_RATE:     cfg_ff.attack_rate     <= csr_wdata[3:0];
            REG_DECAY_RATE:      cfg_ff.decay_rate      <= csr_wdata[3:0];
            REG_SUSTAIN_LEVEL:   cfg_ff.sustain_level   <= csr_wdata[3:0];
            REG_RELEASE_RATE:    cfg_ff.release_rate    <= csr_wdata[3:0];
            REG_SUSTAINED_TONE:  cfg_ff.sustained_tone  <= csr_wdata[0];
            REG_RATE_SCALE_MODE: cfg_ff.rate_scale_mode <= csr_wdata[2:0];
            REG_TOTAL_LEVEL:     cfg_ff.total_level     <= csr_wdata[5:0];
            REG_AM_ENABLE:       cfg_ff.am_enable       <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   fmeg_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   fmeg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .q_full     (q_full),
      .head_item  (head_item),
      .q_ctl_in   (q_ctl),
      .head_valid (head_valid)
   );

   fmeg_back #(
      .LOG_RESOLUTION (LOG_RESOLUTION),
      .ENVELOPE_SHIFT (ENVELOPE_SHIFT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .q_ctl_out       (q_ctl),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_attenuation (rsp_attenuation),
      .rsp_stage       (rsp_stage)
   );

   assign rsp_tdata = {(RSP_DATA_W - ATT_W - STAGE_W)'(0), rsp_stage, rsp_attenuation};

endmodule

`default_nettype wire

@@ design/fmeg_front.sv @@
// Front end: accepts request items and turns rate nibbles into shifts and steps.
`default_nettype none

module fmeg_front
   import fmeg_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire cfg_type               cfg,
   input  wire logic                  q_full,
   output logic                       push,
   output q_item_type                 push_item
);

   logic [3:0] freq_high;
   logic [1:0] ksr_shift;
   logic [3:0] ksr;
   logic [5:0] atk_cap;
   logic [5:0] dec_cap;
   logic [5:0] rel_cap;

   // Accept whenever the queue has room.
   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   assign freq_high = req_tdata[5:2];

   // Key-scale offset: more of the frequency nibble as the mode grows.
   always_comb begin
      ksr_shift = (cfg.rate_scale_mode >= RSM_FULL) ? 2'd0 :
                  2'(RSM_FULL - cfg.rate_scale_mode);
      ksr       = (cfg.rate_scale_mode == RSM_OFF) ? 4'd0 : (freq_high >> ksr_shift);
   end

   // Scaled rates, capped at the top rate.
   assign atk_cap = cap63({1'b0, cfg.attack_rate, 2'b00} + 7'(ksr));
   assign dec_cap = cap63({1'b0, cfg.decay_rate, 2'b00} + 7'(ksr));
   assign rel_cap = cap63({1'b0, cfg.release_rate, 2'b00} + 7'(ksr));

   // Classified item written into the queue.
   always_comb begin
      push_item.mode         = req_tuser;
      push_item.key_on       = req_tdata[0];
      push_item.sustain_on   = req_tdata[1];
      push_item.am_offset    = req_tdata[15:6];
      push_item.attack_shift = (cfg.attack_rate == 4'd0) ? 4'd15 : (4'd15 - atk_cap[5:2]);
      push_item.decay_step   = (cfg.decay_rate == 4'd0) ? 6'd0 : dec_cap;
      push_item.release_step = (cfg.release_rate == 4'd0) ? 6'd0 : rel_cap;
   end

endmodule

`default_nettype wire

@@ design/fmeg_queue.sv @@
// Short item queue that separates the front end from the back end.
`default_nettype none

module fmeg_queue
   import fmeg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire q_item_type push_item,
   output logic            q_full,
   output q_item_type      head_item,
   input  wire q_ctl_type  q_ctl_in,
   output logic            head_valid
);

   q_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              pop;

   assign pop        = q_ctl_in.pop && q_ctl_in.valid && (count_ff != '0);
   assign q_full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   property p_count_bounded;
      @(posedge clock) disable iff (reset)
         count_ff <= QCNT_W'(QUEUE_DEPTH);
   endproperty
   a_count_bounded: assert property (p_count_bounded)
      else $error("queue fill count above its depth");

   property p_pop_drains;
      @(posedge clock) disable iff (reset)
         (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1);
   endproperty
   a_pop_drains: assert property (p_pop_drains)
      else $error("queue count did not drop after a pop");
`endif

endmodule

`default_nettype wire

@@ design/fmeg_back.sv @@
// Back end: envelope state, stage sequencing and the attenuation output pipeline.
`default_nettype none

module fmeg_back
   import fmeg_pkg::*;
#(
   parameter int LOG_RESOLUTION = LOG_RESOLUTION_DEF,
   parameter int ENVELOPE_SHIFT = ENVELOPE_SHIFT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         head_valid,
   input  wire q_item_type   head_item,
   output q_ctl_type         q_ctl_out,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [ATT_W-1:0]  rsp_attenuation,
   output logic [STAGE_W-1:0] rsp_stage
);

   localparam int PW = LOG_RESOLUTION + ENVELOPE_SHIFT + 6;
   localparam logic [PW-1:0] KEYOFF_LEVEL = PW'(1) << (PW - 1);
   localparam logic [PW-1:0] ATTACK_START = PW'(63) << (ENVELOPE_SHIFT + LOG_RESOLUTION - 3);

   typedef enum logic [STAGE_W-1:0] {
      ST_OFF     = 3'd0,
      ST_ATTACK  = 3'd1,
      ST_DECAY   = 3'd2,
      ST_SDECAY  = 3'd3,
      ST_HOLD    = 3'd4,
      ST_RELEASE = 3'd5
   } stage_type;

   // Envelope state.
   stage_type   stage_ff, stage_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [3:0]  attack_shift_ff, attack_shift_in;
   logic [5:0]  decay_step_ff, decay_step_in;
   logic [5:0]  release_step_ff, release_step_in;
   logic        key_ff, key_in;
   logic        sustain_ff, sustain_in;

   // Middle stage and output register.
   logic            mid_valid_ff;
   stage_type       mid_stage_ff;
   logic [PW-1:0]   mid_phase_ff;
   logic [AM_W-1:0] mid_am_ff;
   logic            rsp_valid_ff;
   logic [ATT_W-1:0] rsp_att_ff, rsp_att_in;
   stage_type       rsp_stage_ff;

   logic          advance;
   logic          pop;
   logic [PW-1:0] sus_thresh;
   logic [PW-1:0] atk_dec;
   logic [31:0]   att_sum;
   logic [31:0]   att_full;

   // The pipeline moves when the output register is empty or being taken.
   assign advance   = !rsp_valid_ff || rsp_tready;
   assign pop       = advance && head_valid;
   assign q_ctl_out = '{valid: head_valid, pop: pop};

   assign sus_thresh = PW'(cfg.sustain_level) << (ENVELOPE_SHIFT + LOG_RESOLUTION - 1);
   assign atk_dec    = PW'(1) + (phase_ff >> attack_shift_ff);

   // Next envelope state for the item at the head of the queue.
   always_comb begin
      stage_in        = stage_ff;
      phase_in        = phase_ff;
      attack_shift_in = attack_shift_ff;
      decay_step_in   = decay_step_ff;
      release_step_in = release_step_ff;
      key_in          = key_ff;
      sustain_in      = sustain_ff;
      if (head_item.mode == MODE_UPDATE) begin
         // Key edges, then latch flags and the new rates.
         if (head_item.key_on != key_ff) begin
            key_in = head_item.key_on;
            if (head_item.key_on) begin
               stage_in = ST_ATTACK;
               phase_in = ATTACK_START;
            end else if (stage_ff != ST_OFF) begin
               stage_in = ST_RELEASE;
            end
         end
         sustain_in      = head_item.sustain_on;
         attack_shift_in = head_item.attack_shift;
         decay_step_in   = head_item.decay_step;
         release_step_in = head_item.release_step;
      end else begin
         case (stage_ff)
            ST_ATTACK: begin
               if (phase_ff > atk_dec) begin
                  phase_in = phase_ff - atk_dec;
               end else if (sus_thresh != '0) begin
                  // Attack done; decay starts from zero on the same tick.
                  stage_in = ST_DECAY;
                  phase_in = PW'(decay_step_ff);
               end else begin
                  stage_in = cfg.sustained_tone ? ST_HOLD : ST_SDECAY;
                  phase_in = '0;
               end
            end
            ST_DECAY: begin
               if (phase_ff < sus_thresh) begin
                  phase_in = phase_ff + PW'(decay_step_ff);
               end else begin
                  stage_in = cfg.sustained_tone ? ST_HOLD : ST_SDECAY;
               end
            end
            ST_SDECAY: begin
               if (phase_ff < KEYOFF_LEVEL) begin
                  phase_in = phase_ff + PW'(release_step_ff);
               end else begin
                  stage_in = ST_OFF;
               end
            end
            ST_RELEASE: begin
               if (phase_ff < KEYOFF_LEVEL) begin
                  if (sustain_ff) begin
                     phase_in = phase_ff + PW'(20);
                  end else if (cfg.sustained_tone) begin
                     phase_in = phase_ff + PW'(release_step_ff);
                  end else begin
                     phase_in = phase_ff + PW'(52);
                  end
               end else begin
                  stage_in = ST_OFF;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Attenuation from the middle stage.
   always_comb begin
      att_sum = 32'(mid_phase_ff >> ENVELOPE_SHIFT)
              + (32'(cfg.total_level) << (LOG_RESOLUTION - 3))
              + (cfg.am_enable ? 32'(mid_am_ff) : 32'd0);
      att_full   = (mid_stage_ff == ST_OFF) ? 32'(KEYOFF_LEVEL) : (att_sum << 1);
      rsp_att_in = att_full[ATT_W-1:0];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff        <= ST_OFF;
         phase_ff        <= '0;
         attack_shift_ff <= '0;
         decay_step_ff   <= '0;
         release_step_ff <= '0;
         key_ff          <= 1'b0;
         sustain_ff      <= 1'b0;
         mid_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            stage_ff        <= stage_in;
            phase_ff        <= phase_in;
            attack_shift_ff <= attack_shift_in;
            decay_step_ff   <= decay_step_in;
            release_step_ff <= release_step_in;
            key_ff          <= key_in;
            sustain_ff      <= sustain_in;
         end
         if (advance) begin
            mid_valid_ff <= head_valid;
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         mid_stage_ff <= stage_in;
         mid_phase_ff <= phase_in;
         mid_am_ff    <= head_item.am_offset;
         rsp_att_ff   <= rsp_att_in;
         rsp_stage_ff <= mid_stage_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_attenuation = rsp_att_ff;
   assign rsp_stage       = rsp_stage_ff;

`ifndef SYNTHESIS
   property p_phase_bounded;
      @(posedge clock) disable iff (reset)
         phase_ff <= KEYOFF_LEVEL + PW'(63);
   endproperty
   a_phase_bounded: assert property (p_phase_bounded)
      else $error("envelope phase beyond the key-off level plus one step");

   property p_key_on_attack;
      @(posedge clock) disable iff (reset)
         (pop && head_item.mode == MODE_UPDATE && head_item.key_on && !key_ff)
         |=> (stage_ff == ST_ATTACK && phase_ff == ATTACK_START);
   endproperty
   a_key_on_attack: assert property (p_key_on_attack)
      else $error("key-on did not start the attack");

   property p_mid_holds;
      @(posedge clock) disable iff (reset)
         (mid_valid_ff && !advance) |=> ($stable(mid_phase_ff) && $stable(mid_stage_ff));
   endproperty
   a_mid_holds: assert property (p_mid_holds)
      else $error("middle stage changed while stalled");

   property p_off_entry;
      @(posedge clock) disable iff (reset)
         (stage_ff != ST_OFF) |=> (stage_ff != ST_OFF || $past(stage_ff) == ST_SDECAY
                                   || $past(stage_ff) == ST_RELEASE);
   endproperty
   a_off_entry: assert property (p_off_entry)
      else $error("envelope turned off from a stage that cannot end");
`endif

endmodule

`default_nettype wire
